### rtl/core/bprc_pkg.sv
package bprc_pkg;

  localparam int SEQ_W       = 24;
  localparam int PROT_W      = 32;
  localparam int FIELD_POS_W = 24;
  localparam int COUNT_W     = 23;
  localparam int SCORE_W     = 17;
  localparam int RUN_W       = 5;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 96;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_SPAN = 1'b1;

  localparam logic [RUN_W-1:0] RUN_MAX       = 5'd31;
  localparam logic [CFG_W-1:0] MIN_RUN_RST   = 5'd4;
  localparam logic [CFG_W-1:0] MARK_SPAN_RST = 5'd8;

  localparam int CODON_NT  = 3;
  localparam int QDEPTH    = 2;
  localparam int DIV_STEPS = 17;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 17'd65536;

  localparam int          DIV3_SHIFT = 25;
  localparam logic [47:0] DIV3_MUL   = 48'd11184811;

  typedef struct packed {
    logic [SEQ_W-1:0]       seq_id;
    logic [PROT_W-1:0]      protein;
    logic [COUNT_W-1:0]     count;
    logic [FIELD_POS_W-1:0] len;
  } res_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [COUNT_W-1:0] div3(input logic [FIELD_POS_W-1:0] x);
    logic [47:0] p;
    p = {24'd0, x} * DIV3_MUL;
    return p[DIV3_SHIFT +: COUNT_W];
  endfunction

endpackage

### rtl/core/bprc_queue.sv
module bprc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bprc_pkg::res_req_t push_data,
  input  logic               pop,
  output bprc_pkg::res_req_t pop_data,
  output bprc_pkg::q_stat_t  stat
);
  import bprc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  res_req_t           mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (cnt_r == CNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/bprc_front.sv
module bprc_front #(
  parameter int PW = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [bprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bprc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bprc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  bprc_pkg::q_stat_t                 q_stat,
  output logic                              q_push,
  output bprc_pkg::res_req_t                q_data
);
  import bprc_pkg::*;

  localparam int CW = PW - 1;

  typedef enum logic {F_IDLE, F_EXEC} fstate_t;

  fstate_t             fstate_r;
  logic [CFG_W-1:0]    min_run_r;
  logic [CFG_W-1:0]    span_r;

  logic [SEQ_W-1:0]    it_seq_r;
  logic [PROT_W-1:0]   it_prot_r;
  logic [PW-1:0]       it_pos_r;
  logic [PW-1:0]       it_len_r;
  logic                it_last_r;
  logic [CW-1:0]       it_pos3_r;
  logic [CW-1:0]       it_len3_r;

  logic                act_r,   act_nxt;
  logic [SEQ_W-1:0]    seq_r,   seq_nxt;
  logic [PROT_W-1:0]   prot_r,  prot_nxt;
  logic [PW-1:0]       len_r,   len_nxt;
  logic [CW-1:0]       lim_r,   lim_nxt;
  logic [PW-1:0]       prev_r,  prev_nxt;
  logic [CW-1:0]       rstart_r, rstart_nxt;
  logic [RUN_W-1:0]    run_r,   run_nxt;
  logic [CW-1:0]       mend_r,  mend_nxt;
  logic [CW-1:0]       cov_r,   cov_nxt;
  logic [PROT_W-1:0]   bprot_r, bprot_nxt;
  logic [CW-1:0]       bcnt_r,  bcnt_nxt;
  logic                bval_r,  bval_nxt;

  logic                accept;
  logic [PW-1:0]       pos_in;
  logic [PW-1:0]       len_in;

  assign in_tready = (fstate_r == F_IDLE) && !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign pos_in    = in_tdata[56 +: PW];
  assign len_in    = in_tdata[80 +: PW];

  always_ff @(posedge clk) begin
    if (accept) begin
      it_seq_r  <= in_tdata[23:0];
      it_prot_r <= in_tdata[55:24];
      it_pos_r  <= pos_in;
      it_len_r  <= len_in;
      it_last_r <= in_tlast;
      it_pos3_r <= CW'(div3(FIELD_POS_W'(pos_in)));
      it_len3_r <= CW'(div3(FIELD_POS_W'(len_in)));
    end
  end

  always_comb begin : exec_blk
    logic [PW-1:0] mark_e;
    logic [CW-1:0] mark_s;
    act_nxt    = act_r;
    seq_nxt    = seq_r;
    prot_nxt   = prot_r;
    len_nxt    = len_r;
    lim_nxt    = lim_r;
    prev_nxt   = prev_r;
    rstart_nxt = rstart_r;
    run_nxt    = run_r;
    mend_nxt   = mend_r;
    cov_nxt    = cov_r;
    bprot_nxt  = bprot_r;
    bcnt_nxt   = bcnt_r;
    bval_nxt   = bval_r;
    q_push     = 1'b0;
    q_data     = '0;
    mark_e     = '0;
    mark_s     = '0;
    if (fstate_r == F_EXEC) begin
      if (act_nxt && (it_seq_r != seq_nxt)) begin
        if (!bval_nxt || (cov_nxt > bcnt_nxt)) begin
          bprot_nxt = prot_nxt;
          bcnt_nxt  = cov_nxt;
        end
        q_push         = 1'b1;
        q_data.seq_id  = seq_nxt;
        q_data.protein = bprot_nxt;
        q_data.count   = COUNT_W'(bcnt_nxt);
        q_data.len     = FIELD_POS_W'(len_nxt);
        act_nxt    = 1'b0;
        seq_nxt    = '0;
        prot_nxt   = '0;
        len_nxt    = '0;
        lim_nxt    = '0;
        prev_nxt   = '0;
        rstart_nxt = '0;
        run_nxt    = '0;
        mend_nxt   = '0;
        cov_nxt    = '0;
        bprot_nxt  = '0;
        bcnt_nxt   = '0;
        bval_nxt   = 1'b0;
      end

      if (!act_nxt) begin
        act_nxt    = 1'b1;
        seq_nxt    = it_seq_r;
        len_nxt    = it_len_r;
        lim_nxt    = it_len3_r;
        prot_nxt   = it_prot_r;
        cov_nxt    = '0;
        mend_nxt   = '0;
        run_nxt    = RUN_W'(1);
        rstart_nxt = it_pos3_r;
        prev_nxt   = it_pos_r;
      end else if (it_prot_r != prot_nxt) begin
        if (!bval_nxt || (cov_nxt > bcnt_nxt)) begin
          bprot_nxt = prot_nxt;
          bcnt_nxt  = cov_nxt;
        end
        bval_nxt   = 1'b1;
        prot_nxt   = it_prot_r;
        cov_nxt    = '0;
        mend_nxt   = '0;
        run_nxt    = RUN_W'(1);
        rstart_nxt = it_pos3_r;
        prev_nxt   = it_pos_r;
      end else begin
        if ((PW+1)'(it_pos_r) == (PW+1)'(prev_nxt) + (PW+1)'(CODON_NT)) begin
          if (run_nxt < RUN_MAX) begin
            run_nxt = run_nxt + 1'b1;
          end
        end else begin
          run_nxt    = RUN_W'(1);
          rstart_nxt = it_pos3_r;
        end
        prev_nxt = it_pos_r;
      end

      if (run_nxt >= min_run_r) begin
        mark_e = PW'(it_pos3_r) + PW'(span_r);
        if (mark_e > PW'(lim_nxt)) begin
          mark_e = PW'(lim_nxt);
        end
        mark_s = (rstart_nxt > mend_nxt) ? rstart_nxt : mend_nxt;
        if (mark_e > PW'(mark_s)) begin
          cov_nxt = cov_nxt + CW'(mark_e - PW'(mark_s));
        end
        if (mark_e > PW'(mend_nxt)) begin
          mend_nxt = CW'(mark_e);
        end
      end

      if (it_last_r && !q_push) begin
        if (!bval_nxt || (cov_nxt > bcnt_nxt)) begin
          bprot_nxt = prot_nxt;
          bcnt_nxt  = cov_nxt;
        end
        q_push         = 1'b1;
        q_data.seq_id  = seq_nxt;
        q_data.protein = bprot_nxt;
        q_data.count   = COUNT_W'(bcnt_nxt);
        q_data.len     = FIELD_POS_W'(len_nxt);
        act_nxt    = 1'b0;
        seq_nxt    = '0;
        prot_nxt   = '0;
        len_nxt    = '0;
        lim_nxt    = '0;
        prev_nxt   = '0;
        rstart_nxt = '0;
        run_nxt    = '0;
        mend_nxt   = '0;
        cov_nxt    = '0;
        bprot_nxt  = '0;
        bcnt_nxt   = '0;
        bval_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r  <= F_IDLE;
      min_run_r <= MIN_RUN_RST;
      span_r    <= MARK_SPAN_RST;
      act_r     <= 1'b0;
      seq_r     <= '0;
      prot_r    <= '0;
      len_r     <= '0;
      lim_r     <= '0;
      prev_r    <= '0;
      rstart_r  <= '0;
      run_r     <= '0;
      mend_r    <= '0;
      cov_r     <= '0;
      bprot_r   <= '0;
      bcnt_r    <= '0;
      bval_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_RUN:   min_run_r <= cfg_data;
          REG_MARK_SPAN: span_r    <= cfg_data;
          default: ;
        endcase
      end
      case (fstate_r)
        F_IDLE: begin
          if (accept) begin
            fstate_r <= F_EXEC;
          end
        end
        F_EXEC: begin
          fstate_r <= F_IDLE;
        end
        default: fstate_r <= F_IDLE;
      endcase
      act_r    <= act_nxt;
      seq_r    <= seq_nxt;
      prot_r   <= prot_nxt;
      len_r    <= len_nxt;
      lim_r    <= lim_nxt;
      prev_r   <= prev_nxt;
      rstart_r <= rstart_nxt;
      run_r    <= run_nxt;
      mend_r   <= mend_nxt;
      cov_r    <= cov_nxt;
      bprot_r  <= bprot_nxt;
      bcnt_r   <= bcnt_nxt;
      bval_r   <= bval_nxt;
    end
  end

endmodule

### rtl/core/bprc_back.sv
module bprc_back #(
  parameter int PW = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bprc_pkg::q_stat_t                q_stat,
  input  bprc_pkg::res_req_t               q_data,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bprc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import bprc_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_t;

  bstate_t                 bstate_r;
  logic [SEQ_W-1:0]        job_seq_r;
  logic [PROT_W-1:0]       job_prot_r;
  logic [COUNT_W-1:0]      job_cnt_r;
  logic [PW-1:0]           job_len_r;
  logic [PW-1:0]           rem_r;
  logic [PW-1:0]           rem_nxt;
  logic [DIV_STEPS-1:0]    nbit_r;
  logic [DIV_STEPS-1:0]    quo_r;
  logic [STEP_W-1:0]       step_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic [PW:0]             trial;
  logic                    fits;
  logic [COUNT_W+1:0]      triple;
  logic [SCORE_W-1:0]      score;
  logic                    load_out;

  assign q_pop      = (bstate_r == B_IDLE) && !q_stat.empty;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign load_out   = (bstate_r == B_OUT) && (!out_tvalid_r || out_tready);

  assign triple  = (COUNT_W+2)'(q_data.count) + (COUNT_W+2)'({q_data.count, 1'b0});
  assign trial   = {rem_r, nbit_r[DIV_STEPS-1]};
  assign fits    = trial >= {1'b0, job_len_r};
  assign rem_nxt = fits ? PW'(trial - {1'b0, job_len_r}) : PW'(trial);
  assign score   = (job_len_r == '0) ? '0 :
                   ((quo_r > SCORE_MAX) ? SCORE_MAX : SCORE_W'(quo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r     <= B_IDLE;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (bstate_r)
        B_IDLE: begin
          if (q_pop) begin
            job_seq_r  <= q_data.seq_id;
            job_prot_r <= q_data.protein;
            job_cnt_r  <= q_data.count;
            job_len_r  <= q_data.len[PW-1:0];
            rem_r      <= PW'(triple[COUNT_W+1:1]);
            nbit_r     <= {triple[0], (DIV_STEPS-1)'(0)};
            quo_r      <= '0;
            step_r     <= '0;
            bstate_r   <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r  <= rem_nxt;
          nbit_r <= {nbit_r[DIV_STEPS-2:0], 1'b0};
          quo_r  <= {quo_r[DIV_STEPS-2:0], fits};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            bstate_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (load_out) begin
            out_tdata_r  <= {score, job_cnt_r, job_prot_r, job_seq_r};
            bstate_r     <= B_IDLE;
          end
        end
        default: bstate_r <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/best_protein_by_run_coverage.sv
// Path: an accepted item is registered, then processed in the front's execute state; a result it
// flushes goes through the two-entry queue to the back, which divides and registers it for output.
// Flow: the front takes no new item while it executes the last one or the queue is full;
// results are paced by the 17-step restoring divider that forms the score.
// Reset: synchronous, active low; clears all group state and sets min_run_length to 4
// and mark_span to 8.
module best_protein_by_run_coverage #(
  parameter int POS_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bprc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bprc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seq_id[23:0], protein_id[55:24], nuc_pos[79:56], seq_length[103:80]
  input  logic [bprc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_seq_id[23:0], best_protein[55:24], covered_codons[78:56], score_q16[95:79]
  output logic [bprc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import bprc_pkg::*;

  localparam int PW = (POS_BITS < FIELD_POS_W) ? POS_BITS : FIELD_POS_W;

  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;
  res_req_t q_push_data;
  res_req_t q_pop_data;

  assign cfg_ready = 1'b1;

  bprc_front #(.PW(PW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  bprc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  bprc_back #(.PW(PW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/bprc_checker.sv
module bprc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bprc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import bprc_pkg::*;

  a_item_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:79] <= SCORE_MAX)
    else $error("score above one");

  a_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[78:56] == '0) |-> out_tdata[95:79] == '0)
    else $error("score without coverage");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind best_protein_by_run_coverage bprc_checker u_bprc_checker (.*);

### dv/best_protein_checker.sv
module best_protein_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bprc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bprc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [bprc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [bprc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                               fail_count,
  output int                               awaiting,
  output int                               reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import bprc_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq_id;
    logic [PROT_W-1:0]  protein;
    logic [COUNT_W-1:0] codons;
    logic [SCORE_W-1:0] score;
  } best_report_t;

  best_report_t best_q[$];

  logic [CFG_W-1:0]       min_run;
  logic [CFG_W-1:0]       span;
  logic                   grp_open;
  logic [SEQ_W-1:0]       seq_r;
  logic [PROT_W-1:0]      prot_r;
  logic [FIELD_POS_W-1:0] len_r;
  logic [FIELD_POS_W-1:0] last_pos;
  logic [COUNT_W-1:0]     run_base;
  logic [RUN_W-1:0]       run_len;
  logic [COUNT_W-1:0]     mark_hi;
  logic [COUNT_W-1:0]     cov;
  logic [PROT_W-1:0]      best_prot;
  logic [COUNT_W-1:0]     best_cov;
  logic                   best_ok;
  int                     fails = 0;
  int                     seen = 0;

  initial begin
    fail_count   = 0;
    awaiting     = 0;
    reports_seen = 0;
  end

  function automatic void drop_group();
    grp_open  = 1'b0;
    seq_r     = '0;
    prot_r    = '0;
    len_r     = '0;
    last_pos  = '0;
    run_base  = '0;
    run_len   = '0;
    mark_hi   = '0;
    cov       = '0;
    best_prot = '0;
    best_cov  = '0;
    best_ok   = 1'b0;
  endfunction

  function automatic void settle_best();
    if (!best_ok || cov > best_cov) begin
      best_prot = prot_r;
      best_cov  = cov;
    end
    best_ok = 1'b1;
  endfunction

  function automatic void open_protein(input logic [PROT_W-1:0] p,
                                       input logic [FIELD_POS_W-1:0] pos);
    prot_r   = p;
    cov      = '0;
    mark_hi  = '0;
    run_len  = RUN_W'(1);
    run_base = COUNT_W'(pos / 3);
    last_pos = pos;
  endfunction

  function automatic void extend_cover(input logic [FIELD_POS_W-1:0] pos);
    int unsigned hi;
    int unsigned lim;
    int unsigned lo;
    hi  = pos / 3;
    hi  = hi + span;
    lim = len_r / 3;
    lo  = (run_base > mark_hi) ? run_base : mark_hi;
    if (hi > lim) hi = lim;
    if (hi > lo) cov = cov + COUNT_W'(hi - lo);
    if (hi > mark_hi) mark_hi = COUNT_W'(hi);
  endfunction

  function automatic best_report_t make_report();
    best_report_t r;
    logic [63:0]  q;
    q = 64'd0;
    if (len_r != 0) begin
      q = ((64'd3 * best_cov) << 16) / len_r;
      if (q > 64'd65536) q = 64'd65536;
    end
    r.seq_id  = seq_r;
    r.protein = best_prot;
    r.codons  = best_cov;
    r.score   = q[SCORE_W-1:0];
    return r;
  endfunction

  function automatic bit absorb_match(input logic [SEQ_W-1:0] s,
                                      input logic [PROT_W-1:0] p,
                                      input logic [FIELD_POS_W-1:0] pos,
                                      input logic [FIELD_POS_W-1:0] len,
                                      input logic fin,
                                      output best_report_t rpt);
    bit sent;
    sent = 1'b0;
    rpt  = '0;
    if (grp_open && s != seq_r) begin
      settle_best();
      rpt  = make_report();
      sent = 1'b1;
      drop_group();
    end
    if (!grp_open) begin
      grp_open = 1'b1;
      seq_r    = s;
      len_r    = len;
      open_protein(p, pos);
    end else if (p != prot_r) begin
      settle_best();
      open_protein(p, pos);
    end else begin
      if ({8'd0, pos} == {8'd0, last_pos} + 32'd3) begin
        if (run_len < RUN_MAX) run_len = run_len + 1'b1;
      end else begin
        run_len  = RUN_W'(1);
        run_base = COUNT_W'(pos / 3);
      end
      last_pos = pos;
    end
    if (run_len >= min_run) extend_cover(pos);
    if (fin && !sent) begin
      settle_best();
      rpt  = make_report();
      sent = 1'b1;
      drop_group();
    end
    return sent;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    best_report_t want;
    best_report_t fresh;
    if (!rst_n) begin
      min_run = MIN_RUN_RST;
      span    = MARK_SPAN_RST;
      drop_group();
      best_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_RUN) min_run = cfg_data;
        else if (cfg_index == REG_MARK_SPAN) span = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        seen++;
        if (best_q.size() == 0) begin
          $error("unexpected result: seq %0d protein %0d codons %0d score %0d",
                 out_tdata[23:0], out_tdata[55:24], out_tdata[78:56], out_tdata[95:79]);
          fails++;
        end else begin
          want = best_q.pop_front();
          check_field("out_seq_id", 32'(want.seq_id), 32'(out_tdata[23:0]));
          check_field("best_protein", want.protein, out_tdata[55:24]);
          check_field("covered_codons", 32'(want.codons), 32'(out_tdata[78:56]));
          check_field("score_q16", 32'(want.score), 32'(out_tdata[95:79]));
        end
      end
      if (in_tvalid && in_tready) begin
        if (absorb_match(in_tdata[23:0], in_tdata[55:24], in_tdata[79:56],
                         in_tdata[103:80], in_tlast, fresh))
          best_q.insert(best_q.size(), fresh);
      end
    end
    fail_count   <= fails;
    awaiting     <= best_q.size();
    reports_seen <= seen;
  end

endmodule

### dv/best_protein_by_run_coverage_tb.sv
module best_protein_by_run_coverage_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bprc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASE_ITEMS = 225;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_RUN;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int awaiting;
  int reports_seen;
  int cycles = 0;
  int items_sent = 0;
  int settings_used = 1;
  int burst_left = 0;
  logic [SEQ_W-1:0] gen_seq = '0;
  logic [7:0] ready_clk = '0;
  int ready_mode = 0;

  best_protein_by_run_coverage uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  best_protein_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .awaiting(awaiting), .reports_seen(reports_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    ready_clk <= ready_clk + 1'b1;
    if (ready_clk == 8'd0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 0);
      2: out_tready <= (ready_clk[4:0] == 5'd0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic push_record(input logic [SEQ_W-1:0] s, input logic [PROT_W-1:0] p,
                             input logic [FIELD_POS_W-1:0] pos,
                             input logic [FIELD_POS_W-1:0] len, input logic fin);
    in_tdata  <= {len, pos, p, s};
    in_tlast  <= fin;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 99) < 30) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic gen_sequence(input bit fin);
    logic [FIELD_POS_W-1:0] base;
    logic [FIELD_POS_W-1:0] len;
    logic [FIELD_POS_W-1:0] pos;
    logic [PROT_W-1:0]      prot;
    logic                   tail;
    int nprot, nrec, r, i, j;
    gen_seq = gen_seq + SEQ_W'($urandom_range(1, 3));
    base = ($urandom_range(0, 1) == 0) ? FIELD_POS_W'($urandom_range(0, 3000))
                                       : FIELD_POS_W'($urandom_range(0, 24'hFFF000));
    r = $urandom_range(0, 99);
    if (r < 10) len = '0;
    else if (r < 25) len = FIELD_POS_W'($urandom);
    else if (r < 35) len = 24'hFFFFFF;
    else if (r < 65) len = base + FIELD_POS_W'($urandom_range(0, 200));
    else len = base + FIELD_POS_W'($urandom_range(300, 3300));
    prot  = $urandom;
    nprot = $urandom_range(1, 4);
    for (i = 0; i < nprot; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) nrec = $urandom_range(1, 8);
      else if (r < 90) nrec = $urandom_range(9, 20);
      else nrec = $urandom_range(28, 40);
      if (fin && i == nprot - 1 && nrec < 2) nrec = 2;
      pos = base + FIELD_POS_W'($urandom_range(0, 30));
      for (j = 0; j < nrec; j++) begin
        if (j > 0) begin
          r = $urandom_range(0, 99);
          if (r < 80) pos = pos + 24'd3;
          else if (r < 88) pos = pos + FIELD_POS_W'($urandom_range(4, 40));
          else if (r < 93) pos = pos + FIELD_POS_W'($urandom_range(1, 2));
          else pos = (pos >= 30) ? pos - FIELD_POS_W'($urandom_range(0, 30)) : '0;
        end
        tail = fin && i == nprot - 1 && j == nrec - 1;
        r = fin ? 99 : $urandom_range(0, 99);
        if (r < 2) push_record(gen_seq, prot, pos, len, 1'b1);
        else if (r < 4) push_record(gen_seq, prot, pos, FIELD_POS_W'($urandom), 1'b0);
        else if (r < 6)
          push_record(SEQ_W'($urandom), $urandom, FIELD_POS_W'($urandom),
                      FIELD_POS_W'($urandom), 1'($urandom_range(0, 1)));
        else if (r < 7) push_record(gen_seq - 1'b1, prot, pos, len, 1'b0);
        else push_record(gen_seq, prot, pos, len, tail);
      end
      if (!fin && $urandom_range(0, 99) < 5) prot = prot - PROT_W'($urandom_range(1, 50));
      else prot = prot + PROT_W'($urandom_range(1, 1000));
    end
  endtask

  task automatic random_stream(input int target);
    int start;
    start   = items_sent;
    gen_seq = SEQ_W'($urandom);
    while (items_sent - start < target) gen_sequence(1'b0);
    gen_sequence(1'b1);
    settle();
  endtask

  task automatic drive_phase(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] s);
    write_reg(REG_MIN_RUN, m);
    write_reg(REG_MARK_SPAN, s);
    settings_used++;
    random_stream(PHASE_ITEMS);
  endtask

  task automatic directed_items();
    int k;
    push_record(24'd0, 32'd0, 24'd0, 24'd0, 1'b1);
    for (k = 0; k < 5; k++) push_record(24'd1, 32'd5, FIELD_POS_W'(3 * k), 24'd30, 1'b0);
    for (k = 0; k < 4; k++) push_record(24'd1, 32'd7, FIELD_POS_W'(3 * k), 24'd30, 1'b0);
    push_record(24'd1, 32'd7, 24'd3, 24'd30, 1'b0);
    push_record(24'd1, 32'd9, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    push_record(24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    push_record(24'd2, 32'd0, 24'd0, 24'hFFFFFF, 1'b1);
    push_record(24'd2, 32'd0, 24'd3, 24'd0, 1'b1);
    for (k = 0; k < 9; k++)
      push_record(24'd3, 32'h80000000, FIELD_POS_W'(300 + 3 * k), 24'hFFFFFF, k == 8);
    settle();
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("best_protein_by_run_coverage: mismatch");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    random_stream(PHASE_ITEMS);
    drive_phase(5'd1, 5'd1);
    drive_phase(5'd16, 5'd16);
    drive_phase(5'd0, 5'd0);
    drive_phase(5'd31, 5'd31);
    drive_phase(5'd3, 5'd5);
    drive_phase(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)));
    $display("%0d match records sent under %0d register settings", items_sent, settings_used);
    $display("%0d best-protein reports compared, %0d cycles", reports_seen, cycles);
    if (fail_count == 0) begin
      $display("best_protein_by_run_coverage: match");
    end else begin
      $display("best_protein_by_run_coverage: mismatch");
    end
    $finish;
  end

endmodule

### best_protein_by_run_coverage.f
rtl/core/bprc_pkg.sv
rtl/core/bprc_queue.sv
rtl/core/bprc_front.sv
rtl/core/bprc_back.sv
rtl/core/best_protein_by_run_coverage.sv
rtl/core/bprc_checker.sv
dv/best_protein_checker.sv
dv/best_protein_by_run_coverage_tb.sv
